@@ rtl/core/unique_pair_binding_table_defines.svh @@
// Assertion macros shared by the binding table RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef UNIQUE_PAIR_BINDING_TABLE_DEFINES_SVH
`define UNIQUE_PAIR_BINDING_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define UPBT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define UPBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/upbt_pkg.sv @@
// ----------------------------------------------------------------------------
// upbt_pkg
// Shared constants, codes, types and the key trimming function of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package upbt_pkg;

  localparam int ENTRIES   = 16;
  localparam int KEY_BYTES = 7;
  localparam int KEY_W     = KEY_BYTES * 8;
  localparam int ADDR_W    = 16;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_RECORD = 2'd1;
  localparam logic [OP_W-1:0] OP_FORGET = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID  = 2'd1;
  localparam logic [ST_W-1:0] ST_NOSPACE  = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  // Command held steady for the whole item; the flags are already qualified
  // by argument checks, so a cell only acts when its flag is set.
  typedef struct packed {
    logic              lookup;
    logic              record;
    logic              forget;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  key;
  } cmd_t;

  // Token that walks the row of cells, one cell per cycle.
  typedef struct packed {
    logic             valid;
    logic             pass2;
    logic             hit;
    logic             claimed;
    logic [CNT_W-1:0] evicts;
    logic [KEY_W-1:0] key;
  } tok_t;

  // Keep the bytes of the key up to, not including, its first zero byte.
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
    logic             alive;
    logic [KEY_W-1:0] r;
    alive = 1'b1;
    r     = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (k[8*i +: 8] == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        r[8*i +: 8] = k[8*i +: 8];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/upbt_cell.sv @@
// ----------------------------------------------------------------------------
// upbt_cell
// One table entry; updates itself as the token passes and forwards it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module upbt_cell import upbt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  tok_t tok_in,
  output tok_t tok_out
);

  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] addr_next;
  logic [KEY_W-1:0]  key;
  logic [KEY_W-1:0]  key_next;
  tok_t              tok_next;
  logic              occ;
  logic              match;
  logic              same_key;

  assign occ      = (addr != '0);
  assign match    = occ && (addr == cmd.addr);
  assign same_key = (key == cmd.key);

  // The first pass does lookups, evictions and forgets and notes whether the
  // address is bound anywhere; the second pass places a recorded binding.
  always_comb begin
    addr_next = addr;
    key_next  = key;
    tok_next  = tok_in;
    if (tok_in.valid) begin
      if (!tok_in.pass2) begin
        if (cmd.lookup && match && !tok_in.hit) begin
          tok_next.hit = 1'b1;
          tok_next.key = key;
        end
        if (cmd.record) begin
          if (match) begin
            tok_next.hit = 1'b1;
          end else if (occ && same_key) begin
            addr_next       = '0;
            tok_next.evicts = tok_in.evicts + CNT_W'(1);
          end
        end
        if (cmd.forget && match && !tok_in.hit) begin
          addr_next    = '0;
          tok_next.hit = 1'b1;
        end
      end else if (cmd.record) begin
        if (tok_in.hit) begin
          if (match) begin
            key_next = cmd.key;
          end
        end else if (!tok_in.claimed && !occ) begin
          addr_next        = cmd.addr;
          key_next         = cmd.key;
          tok_next.claimed = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr    <= '0;
      tok_out <= '0;
    end else begin
      addr    <= addr_next;
      tok_out <= tok_next;
    end
  end

  // The key is only read behind a nonzero address, so it needs no reset.
  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

`default_nettype wire

@@ rtl/core/unique_pair_binding_table.sv @@
// ----------------------------------------------------------------------------
// unique_pair_binding_table
// One-to-one table of node addresses and short name keys, built as a row of
// entry cells that a command token walks through.
// ----------------------------------------------------------------------------
// Usage: an item enters on the input channel (in_valid/in_ready) with an
// operation, a node address and a name key. Exactly one result item leaves
// on the output channel (out_valid/out_ready) with a status, the found key
// and the number of occupied entries after the item.
// Each entry lives in its own cell. A token walks the row one cell per cycle,
// twice per item: the first pass looks up, evicts entries that hold the same
// key under another address, forgets, and learns whether the address is
// already bound; the second pass rewrites that entry or claims the first
// empty one. The result is registered once the token is back from its
// second pass, and the next item can be taken once that result has moved
// into the output register; until then the block takes no new item.
// Only one item is in flight. in_ready is high while the block is idle, also
// while a previous result still waits in the output register.
// When the receiver stalls, a finished item waits inside the block until the
// output register frees up; the output holds steady until taken.
// Synchronous reset empties every entry, zeroes the count and drops any
// pending item or result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "unique_pair_binding_table_defines.svh"

module unique_pair_binding_table import upbt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   operation,
  input  logic [ADDR_W-1:0] node_address,
  input  logic [KEY_W-1:0]  name_key,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ST_W-1:0]   status,
  output logic [KEY_W-1:0]  found_key,
  output logic [CNT_W-1:0]  entry_count
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state;
  cmd_t             cmd;
  cmd_t             cmd_next;
  logic [OP_W-1:0]  op;
  tok_t             head;
  tok_t             launch;
  tok_t             relaunch;
  tok_t             link [ENTRIES+1];
  tok_t             tail;
  logic [ENTRIES:0] tok_live;
  logic [CNT_W-1:0] count;
  logic [ST_W-1:0]  res_status;
  logic [KEY_W-1:0] res_key;
  logic [CNT_W-1:0] res_count;
  logic [ST_W-1:0]  res_status_next;
  logic [KEY_W-1:0] res_key_next;
  logic [CNT_W-1:0] res_count_next;
  logic             accept;
  logic             out_free;
  logic             fill;
  logic             drop;
  logic [KEY_W-1:0] key_in;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign key_in   = norm_key(name_key);

  // Argument checks happen once, here; the cells only see qualified flags.
  always_comb begin
    cmd_next.addr   = node_address;
    cmd_next.key    = key_in;
    cmd_next.lookup = (operation == OP_LOOKUP) && (node_address != '0);
    cmd_next.record = (operation == OP_RECORD) && (node_address != '0) &&
                      (key_in != '0);
    cmd_next.forget = (operation == OP_FORGET) && (node_address != '0);
  end

  // A fresh token starts the first pass; the token that returns from the
  // first pass goes round again, keeping what it learned, for the second.
  always_comb begin
    launch         = '0;
    launch.valid   = 1'b1;
    relaunch       = tail;
    relaunch.pass2 = 1'b1;
  end

  assign link[0] = head;
  assign tail    = link[ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    upbt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .tok_in  (link[i]),
      .tok_out (link[i+1])
    );
  end

  for (genvar i = 0; i <= ENTRIES; i++) begin : g_live
    assign tok_live[i] = link[i].valid;
  end

  // Outcome of the item once the token is back from its second pass.
  assign fill = cmd.record && !tail.hit && tail.claimed;
  assign drop = cmd.forget && tail.hit;

  always_comb begin
    res_count_next = count - tail.evicts - CNT_W'(drop) + CNT_W'(fill);
    res_key_next   = '0;
    case (op)
      OP_LOOKUP: begin
        res_status_next = tail.hit ? ST_OK : ST_NOTFOUND;
        if (tail.hit) begin
          res_key_next = tail.key;
        end
      end
      OP_RECORD: begin
        if (!cmd.record) begin
          res_status_next = ST_INVALID;
        end else if (!tail.hit && !tail.claimed) begin
          res_status_next = ST_NOSPACE;
        end else begin
          res_status_next = ST_OK;
        end
      end
      OP_FORGET: begin
        res_status_next = ST_OK;
      end
      default: begin
        res_status_next = ST_INVALID;
      end
    endcase
  end

  // Control: sequencer, token head, output handshake and the entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      // A new result loads the output register as soon as it is free;
      // otherwise a taken result empties it.
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            head  <= launch;
            state <= S_RUN;
          end else begin
            head <= '0;
          end
        end
        S_RUN: begin
          if (tail.valid && !tail.pass2) begin
            head <= relaunch;
          end else begin
            head <= '0;
            if (tail.valid) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          head <= '0;
          if (out_free) begin
            count <= res_count;
            state <= S_IDLE;
          end
        end
        default: begin
          head  <= '0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
      op  <= operation;
    end
    if (state == S_RUN && tail.valid && tail.pass2) begin
      res_status <= res_status_next;
      res_key    <= res_key_next;
      res_count  <= res_count_next;
    end
    if (state == S_DONE && out_free) begin
      status      <= res_status;
      found_key   <= res_key;
      entry_count <= res_count;
    end
  end

  `UPBT_ASSERT(a_count_range, 1'b1, count <= CNT_W'(ENTRIES), "entry count above table size")
  `UPBT_ASSERT(a_one_token, 1'b1, $countones(tok_live) <= 1, "more than one token in the row")
  `UPBT_ASSERT(a_idle_quiet, state == S_IDLE, $countones(tok_live) == 0, "token alive while idle")
  `UPBT_ASSERT_NEXT(a_launch, accept, head.valid && state == S_RUN, "accepted item not launched")
  `UPBT_ASSERT(a_key_clean, out_valid && status != ST_OK, found_key == '0, "key on failed item")

endmodule

`default_nettype wire

@@ tb/binding_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binding_table_checker
// Keeps a shadow copy of the address/key table. It predicts the result of
// every item that the table accepts, and compares each result that leaves
// the table with the oldest prediction.
// ----------------------------------------------------------------------------

module binding_table_checker import upbt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [OP_W-1:0]   operation,
  input  logic [ADDR_W-1:0] node_address,
  input  logic [KEY_W-1:0]  name_key,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [ST_W-1:0]   status,
  input  logic [KEY_W-1:0]  found_key,
  input  logic [CNT_W-1:0]  entry_count,
  output int                mismatches,
  output int                outstanding
);

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } binding_result_t;

  logic [ADDR_W-1:0] shadow_addr [ENTRIES];
  logic [KEY_W-1:0]  shadow_key  [ENTRIES];
  int                shadow_count;
  binding_result_t   pending_results [$];
  int                fail_count = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // A key ends at its first zero byte.
  function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] kept;
    kept = '0;
    for (int b = 0; b < KEY_BYTES && raw[8*b +: 8] != 8'd0; b++) begin
      kept[8*b +: 8] = raw[8*b +: 8];
    end
    return kept;
  endfunction

  task automatic drop_entry(input int idx);
    shadow_addr[idx] = '0;
    shadow_key[idx]  = '0;
    if (shadow_count > 0) begin
      shadow_count--;
    end
  endtask

  task automatic apply_binding_item(input logic [OP_W-1:0] op,
                                    input logic [ADDR_W-1:0] addr,
                                    input logic [KEY_W-1:0] raw_key,
                                    output binding_result_t res);
    logic [KEY_W-1:0] key;
    int               slot;
    int               empty;
    logic             hit;
    key        = trim_key(raw_key);
    res.status = ST_OK;
    res.key    = '0;
    hit        = 1'b0;
    slot       = -1;
    empty      = -1;
    case (op)
      OP_LOOKUP: begin
        res.status = ST_NOTFOUND;
        if (addr != '0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (!hit && shadow_addr[i] == addr) begin
              hit        = 1'b1;
              res.key    = shadow_key[i];
              res.status = ST_OK;
            end
          end
        end
      end
      OP_RECORD: begin
        if (addr == '0 || key == '0) begin
          res.status = ST_INVALID;
        end else begin
          // The same key under another address loses its entry first.
          for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_addr[i] != '0 && shadow_addr[i] != addr &&
                shadow_key[i] == key) begin
              drop_entry(i);
            end
          end
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0) begin
              if (shadow_addr[i] == addr) begin
                slot = i;
              end else if (empty < 0 && shadow_addr[i] == '0) begin
                empty = i;
              end
            end
          end
          if (slot < 0) begin
            if (empty < 0) begin
              res.status = ST_NOSPACE;
            end else begin
              slot = empty;
              shadow_count++;
            end
          end
          if (slot >= 0) begin
            shadow_addr[slot] = addr;
            shadow_key[slot]  = key;
          end
        end
      end
      OP_FORGET: begin
        if (addr != '0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (!hit && shadow_addr[i] == addr) begin
              hit = 1'b1;
              drop_entry(i);
            end
          end
        end
      end
      default: begin
        res.status = ST_INVALID;
      end
    endcase
    res.count = shadow_count[CNT_W-1:0];
  endtask

  task automatic note_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, field, want, got);
    end
  endtask

  always @(posedge clk) begin : track
    binding_result_t want;
    binding_result_t predicted;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        shadow_addr[i] = '0;
        shadow_key[i]  = '0;
      end
      shadow_count = 0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result item with none expected, status %h key %h count %h",
                     $realtime, status, found_key, entry_count);
          end
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            note_mismatch("status", 64'(want.status), 64'(status));
          end
          if (found_key !== want.key) begin
            note_mismatch("found_key", 64'(want.key), 64'(found_key));
          end
          if (entry_count !== want.count) begin
            note_mismatch("entry_count", 64'(want.count), 64'(entry_count));
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_binding_item(operation, node_address, name_key, predicted);
        pending_results.push_back(predicted);
      end
    end
    mismatches  <= fail_count;
    outstanding <= pending_results.size();
  end

endmodule

@@ tb/unique_pair_binding_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_pair_binding_table_tb
// Drives lookup, record, forget and unused-code items into the table: first a
// short directed list of corner cases, then random items drawn from small
// address and key pools so that the table fills up, keys move between
// addresses and records run out of space. Both channels idle at random, and
// once the receiver holds off long enough to stall the input. The checker
// beside the table predicts and compares every result.
// ----------------------------------------------------------------------------

module unique_pair_binding_table_tb;
  import upbt_pkg::*;

  // The spare operation code is not named in the package.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1285;
  localparam int ADDR_POOL    = 30;
  localparam int KEY_POOL     = 28;
  localparam int HOLD_CYCLES  = 400;
  localparam int ITEM_CYCLES  = 2 * ENTRIES + 4;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   operation    = OP_LOOKUP;
  logic [ADDR_W-1:0] node_address = '0;
  logic [KEY_W-1:0]  name_key     = '0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic [ST_W-1:0]   status;
  logic [KEY_W-1:0]  found_key;
  logic [CNT_W-1:0]  entry_count;

  int mismatches;
  int outstanding;

  // Random idling switches for each side, and the one-shot request for a
  // long receiver hold-off.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req   = 1'b0;

  logic [ADDR_W-1:0] addr_pool [ADDR_POOL];
  logic [KEY_W-1:0]  key_pool  [KEY_POOL];

  always #2 clk = ~clk;

  unique_pair_binding_table dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .node_address (node_address),
    .name_key     (name_key),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .found_key    (found_key),
    .entry_count  (entry_count)
  );

  binding_table_checker scoreboard (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .node_address (node_address),
    .name_key     (name_key),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .found_key    (found_key),
    .entry_count  (entry_count),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // Offer one item and return at the edge where it is taken. Idle cycles
  // come before the item, never while it is offered, so valid holds steady
  // with its payload until the handshake.
  task automatic offer_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                            input logic [KEY_W-1:0] key);
    while (tx_idle_on && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    node_address <= addr;
    name_key     <= key;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // Fill the bytes above the terminating zero with noise. The table must
  // ignore them, so a pool key with a tail still names the same binding.
  function automatic logic [KEY_W-1:0] add_tail(input logic [KEY_W-1:0] key);
    int           len;
    logic [63:0]  noise;
    len   = 0;
    noise = {$urandom, $urandom};
    while (len < KEY_BYTES && key[8*len +: 8] != 8'd0) begin
      len++;
    end
    if (len >= KEY_BYTES - 1) begin
      return key;
    end
    return key | KEY_W'(noise << (8 * (len + 1)));
  endfunction

  // Most random items use the small pools, so the table fills, records run
  // out of space and keys get re-bound to other addresses. A few items carry
  // fully random fields, which also exercises every bit of every field.
  task automatic random_item();
    int                pick;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  key;
    pick = $urandom_range(0, 99);
    if (pick < 7) begin
      op   = OP_W'($urandom_range(0, 3));
      addr = ADDR_W'($urandom);
      key  = KEY_W'({$urandom, $urandom});
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        op = OP_LOOKUP;
      end else if (pick < 82) begin
        op = OP_RECORD;
      end else if (pick < 96) begin
        op = OP_FORGET;
      end else begin
        op = OP_UNUSED;
      end
      addr = ($urandom_range(0, 99) < 5) ? '0 : addr_pool[$urandom_range(0, ADDR_POOL - 1)];
      key  = key_pool[$urandom_range(0, KEY_POOL - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        key = add_tail(key);
      end else if (pick < 33) begin
        // An empty key with live bytes behind its leading zero.
        key = {key[KEY_W-9:0], 8'd0};
      end
    end
    offer_item(op, addr, key);
  endtask

  // Receiver: random stalls, and one long hold-off when the stimulus asks.
  // Each pass of the loop without a hold-off makes exactly one assignment to out_ready.
  initial begin
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
        out_ready <= 1'b1;
      end else begin
        out_ready <= rx_idle_on ? ($urandom_range(0, 99) >= 23) : 1'b1;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int len;
    for (int i = 0; i < ADDR_POOL; i++) begin
      addr_pool[i] = ADDR_W'($urandom_range(1, 65535));
    end
    // Keep the extreme addresses in the pool.
    addr_pool[0] = '1;
    addr_pool[1] = ADDR_W'(1);
    for (int i = 0; i < KEY_POOL; i++) begin
      len         = $urandom_range(1, KEY_BYTES);
      key_pool[i] = '0;
      for (int b = 0; b < len; b++) begin
        key_pool[i][8*b +: 8] = 8'($urandom_range(1, 255));
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Lookups of address zero and of an address that was never bound.
    offer_item(OP_LOOKUP, '0, '0);
    offer_item(OP_LOOKUP, '1, '1);
    // Records that are rejected: address zero, an all-zero key, and a key
    // whose first byte is zero although later bytes are not.
    offer_item(OP_RECORD, '0, KEY_W'(56'h41));
    offer_item(OP_RECORD, ADDR_W'(5), '0);
    offer_item(OP_RECORD, ADDR_W'(5), KEY_W'(56'h0000_0000_0041_00));
    // Highest address with a full-length all-ones key.
    offer_item(OP_RECORD, '1, '1);
    offer_item(OP_RECORD, ADDR_W'(1), KEY_W'(56'h4241));
    offer_item(OP_LOOKUP, ADDR_W'(1), '0);
    // The same key with noise after its terminator moves the binding from
    // address 1 to address 2.
    offer_item(OP_RECORD, ADDR_W'(2), KEY_W'(56'h6655_4433_0042_41));
    offer_item(OP_LOOKUP, ADDR_W'(1), '0);
    offer_item(OP_LOOKUP, ADDR_W'(2), '0);
    // Rewriting the key of a bound address keeps its entry.
    offer_item(OP_RECORD, ADDR_W'(2), KEY_W'(56'h43));
    offer_item(OP_LOOKUP, ADDR_W'(2), '1);
    // Forgetting address zero or an unbound address changes nothing.
    offer_item(OP_FORGET, '0, '0);
    offer_item(OP_FORGET, ADDR_W'(3), '0);
    offer_item(OP_FORGET, ADDR_W'(2), '0);
    offer_item(OP_UNUSED, '1, '1);
    offer_item(OP_LOOKUP, '1, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // A long stretch with no idling on either side.
      if (n == 400) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else if (n == 700) begin
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
      end
      // The receiver stops for a long time while items keep coming, so the
      // table fills its output and then refuses new items.
      if (n == 800) begin
        hold_req = 1'b1;
      end
      random_item();
    end
    in_valid <= 1'b0;

    // Let the last prediction land, drain, then allow one item time more so
    // a stray extra result would still show up.
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (ITEM_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("unique_pair_binding_table verification clean");
    end else begin
      $display("unique_pair_binding_table verification failed");
    end
    $finish;
  end

  // Hard limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("unique_pair_binding_table verification failed");
    $finish;
  end

endmodule
